// ----- sv/efc_pkg.sv -----
package efc_pkg;

    // Frame geometry and counter arithmetic of the protection scheme.
    localparam int FRAME_BYTES   = 64;
    localparam int COUNTER_MOD   = 15;
    localparam int COUNTER_LIMIT = 15;

    // Byte position saturates at FRAME_BYTES, so it must be able to hold it.
    localparam int POS_W = $clog2(FRAME_BYTES + 1);

    // Configuration port widths.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COUNTER_OFFSET = 3'd0,
        CFG_CRC_OFFSET     = 3'd1,
        CFG_DATA_LENGTH    = 3'd2,
        CFG_MAX_DELTA      = 3'd3,
        CFG_MAX_NO_NEW     = 3'd4,
        CFG_SYNC_INIT      = 3'd5,
        CFG_NEW_MAPPING    = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NONEW    = 3'd1,
        ST_WRONGCRC = 3'd2,
        ST_SYNC     = 3'd3,
        ST_INITIAL  = 3'd4,
        ST_REPEATED = 3'd5,
        ST_SOMELOST = 3'd6,
        ST_WRONGSEQ = 3'd7
    } t_status;

    typedef enum logic [2:0] {
        GEN_OK       = 3'd0,
        GEN_REPEATED = 3'd1,
        GEN_WRONGSEQ = 3'd2,
        GEN_ERROR    = 3'd3,
        GEN_NONEW    = 3'd4
    } t_generic;

    // What the byte path has gathered once the current byte is included.
    typedef struct packed {
        logic [3:0] counter;
        logic [7:0] crc_rx;
        logic [7:0] crc_calc;
    } t_frame_view;

    // Configuration seen by the sequence checker.
    typedef struct packed {
        logic [3:0] max_delta_init;
        logic [3:0] max_no_new;
        logic [3:0] sync_init;
        logic       new_mapping;
    } t_seq_cfg;

    // One result item.
    typedef struct packed {
        t_status    check_status;
        logic       return_code;
        logic [3:0] lost_frames;
        t_generic   generic_status;
    } t_result;

endpackage

// ----- sv/efc_frame_acc.sv -----
module efc_frame_acc (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_byte_step,
    input  logic                  i_frame_end,
    input  logic [7:0]            i_frame_byte,
    input  logic [8:0]            i_counter_offset_bits,
    input  logic [8:0]            i_crc_offset_bits,
    input  logic [9:0]            i_data_length_bits,
    output efc_pkg::t_frame_view  o_view
);
    import efc_pkg::*;

    localparam int CMP_W = (POS_W > 7) ? POS_W : 7;

    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_crc, n_crc;
    logic [3:0]       r_cnt, n_cnt;
    logic [7:0]       r_crc_rx, n_crc_rx;

    logic [CMP_W-1:0] pos_x, cnt_idx, crc_idx, len_bytes;
    logic             in_range;

    // One byte of CRC-8 SAE J1850, polynomial 0x1D, bit by bit.
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ 8'h1D) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    assign pos_x     = CMP_W'(r_pos);
    assign cnt_idx   = CMP_W'(i_counter_offset_bits[8:3]);
    assign crc_idx   = CMP_W'(i_crc_offset_bits[8:3]);
    assign len_bytes = CMP_W'(i_data_length_bits[9:3]);
    assign in_range  = (r_pos < POS_W'(FRAME_BYTES));

    always_comb begin
        n_pos    = r_pos;
        n_crc    = r_crc;
        n_cnt    = r_cnt;
        n_crc_rx = r_crc_rx;
        if (in_range) begin
            if (pos_x == cnt_idx) begin
                n_cnt = (i_counter_offset_bits[2:0] == 3'd0) ? i_frame_byte[3:0]
                                                             : i_frame_byte[7:4];
            end
            if (pos_x == crc_idx) begin
                n_crc_rx = i_frame_byte;
            end
            if ((pos_x < crc_idx) || ((pos_x > crc_idx) && (pos_x < len_bytes))) begin
                n_crc = crc8_step(r_crc, i_frame_byte);
            end
            n_pos = r_pos + 1'b1;
        end
    end

    assign o_view.counter  = n_cnt;
    assign o_view.crc_rx   = n_crc_rx;
    assign o_view.crc_calc = n_crc ^ 8'hFF;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_crc    <= 8'hFF;
            r_cnt    <= '0;
            r_crc_rx <= '0;
        end else if (i_byte_step && i_frame_end) begin
            r_pos    <= '0;
            r_crc    <= 8'hFF;
            r_cnt    <= '0;
            r_crc_rx <= '0;
        end else if (i_byte_step) begin
            r_pos    <= n_pos;
            r_crc    <= n_crc;
            r_cnt    <= n_cnt;
            r_crc_rx <= n_crc_rx;
        end
    end

endmodule

// ----- sv/efc_seq_check.sv -----
module efc_seq_check (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_event,
    input  logic                  i_new_data,
    input  efc_pkg::t_frame_view  i_view,
    input  efc_pkg::t_seq_cfg     i_cfg,
    output efc_pkg::t_result      o_result
);
    import efc_pkg::*;

    logic [3:0] r_last_cnt, n_last_cnt;
    logic [3:0] r_allowed, n_allowed;
    logic       r_waiting, n_waiting;
    logic [3:0] r_lost, n_lost;
    t_status    r_status, n_status;
    logic [3:0] r_sync, n_sync;
    logic [3:0] r_repeat, n_repeat;

    logic [3:0] allowed_inc, repeat_inc, delta, rc;
    logic [4:0] delta_wrap;
    logic       rcode;

    function automatic t_generic to_generic(input t_status st, input logic new_map);
        t_generic g;
        unique case (st)
            ST_OK, ST_SOMELOST: g = GEN_OK;
            ST_NONEW:           g = GEN_NONEW;
            ST_SYNC:            g = new_map ? GEN_OK : GEN_WRONGSEQ;
            ST_INITIAL:         g = new_map ? GEN_WRONGSEQ : GEN_OK;
            ST_REPEATED:        g = GEN_REPEATED;
            ST_WRONGSEQ:        g = GEN_WRONGSEQ;
            ST_WRONGCRC:        g = GEN_ERROR;
            default:            g = GEN_ERROR;
        endcase
        return g;
    endfunction

    assign rc          = i_view.counter;
    assign allowed_inc = (r_allowed < 4'(COUNTER_LIMIT)) ? r_allowed + 4'd1 : r_allowed;
    assign repeat_inc  = (r_repeat < 4'(COUNTER_LIMIT)) ? r_repeat + 4'd1 : r_repeat;
    assign delta_wrap  = 5'(COUNTER_MOD) + {1'b0, rc} - {1'b0, r_last_cnt};
    assign delta       = (rc >= r_last_cnt) ? (rc - r_last_cnt) : delta_wrap[3:0];

    always_comb begin
        n_last_cnt = r_last_cnt;
        n_allowed  = allowed_inc;
        n_waiting  = r_waiting;
        n_lost     = r_lost;
        n_status   = r_status;
        n_sync     = r_sync;
        n_repeat   = r_repeat;
        rcode      = 1'b0;
        priority if (!i_new_data) begin
            n_repeat = repeat_inc;
            n_status = ST_NONEW;
        end else if (rc == 4'd0) begin
            rcode = 1'b1;
        end else if (i_view.crc_rx != i_view.crc_calc) begin
            n_status = ST_WRONGCRC;
        end else if (r_waiting) begin
            n_waiting  = 1'b0;
            n_allowed  = i_cfg.max_delta_init;
            n_last_cnt = rc;
            n_status   = ST_INITIAL;
        end else if (delta == 4'd0) begin
            n_repeat = repeat_inc;
            n_status = ST_REPEATED;
        end else if ((delta == 4'd1) || (delta < allowed_inc)) begin
            // Frame accepted; a jump above one means some frames were lost.
            n_allowed  = i_cfg.max_delta_init;
            n_last_cnt = rc;
            n_lost     = delta - 4'd1;
            n_repeat   = '0;
            if (r_repeat <= i_cfg.max_no_new) begin
                if (r_sync != 4'd0) begin
                    n_sync   = r_sync - 4'd1;
                    n_status = ST_SYNC;
                end else begin
                    n_status = (delta == 4'd1) ? ST_OK : ST_SOMELOST;
                end
            end else begin
                n_sync   = i_cfg.sync_init;
                n_status = ST_SYNC;
            end
        end else begin
            n_repeat = '0;
            n_sync   = i_cfg.sync_init;
            if (i_cfg.sync_init != 4'd0) begin
                n_allowed  = i_cfg.max_delta_init;
                n_last_cnt = rc;
            end
            n_status = ST_WRONGSEQ;
        end
    end

    assign o_result.check_status   = n_status;
    assign o_result.return_code    = rcode;
    assign o_result.lost_frames    = n_lost;
    assign o_result.generic_status = rcode ? GEN_ERROR : to_generic(n_status, i_cfg.new_mapping);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_cnt <= '0;
            r_allowed  <= '0;
            r_waiting  <= 1'b1;
            r_lost     <= '0;
            r_status   <= ST_NONEW;
            r_sync     <= '0;
            r_repeat   <= '0;
        end else if (i_event) begin
            r_last_cnt <= n_last_cnt;
            r_allowed  <= n_allowed;
            r_waiting  <= n_waiting;
            r_lost     <= n_lost;
            r_status   <= n_status;
            r_sync     <= n_sync;
            r_repeat   <= n_repeat;
        end
    end

endmodule

// ----- sv/e2e_frame_check.sv -----
// End-to-end frame receive check.
// Frame bytes enter one request at a time on the input channel (i_in_valid,
// o_in_stall), in order from byte zero; i_last_byte marks the final byte.
// A request with i_new_data low stands for a missing frame and leaves any
// frame in progress untouched.
// Each request is captured in an input register and processed from there:
// the CRC-8 step, the counter and CRC capture and, at frame end, the
// counter delta check all complete in that stage, and the result is
// loaded into the output register.
// Bytes without the last mark give no result.
// Throughput is one request per cycle while the output side keeps up.
// When the receiver raises i_out_stall with a result pending, the result is
// held and the input register fills; o_in_stall then rises until the output
// register drains.
// Configuration is written through i_cfg_valid / o_cfg_ready, which is always
// ready, and must only change while the block is idle.
// Reset (i_rst_n low, synchronous) restores every configuration register to
// its default, empties both registers and returns the checker to waiting for
// its first valid frame.
module e2e_frame_check (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input request channel.
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [7:0]                      i_frame_byte,
    input  logic                            i_last_byte,
    input  logic                            i_new_data,
    // Result channel.
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [2:0]                      o_check_status,
    output logic                            o_return_code,
    output logic [3:0]                      o_lost_frames,
    output logic [2:0]                      o_generic_status,
    // Configuration write channel.
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [efc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [efc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import efc_pkg::*;

    // Configuration registers.
    logic [8:0] r_counter_offset_bits;
    logic [8:0] r_crc_offset_bits;
    logic [9:0] r_data_length_bits;
    logic [3:0] r_max_delta_init;
    logic [3:0] r_max_no_new;
    logic [3:0] r_sync_init;
    logic       r_new_mapping;

    // Input register.
    logic       r_s1_valid, n_s1_valid;
    logic [7:0] r_s1_byte;
    logic       r_s1_last;
    logic       r_s1_nd;

    // Output register.
    logic       r_out_valid, n_out_valid;
    t_result    r_out;

    logic        out_free;
    logic        s1_go;
    logic        in_take;
    logic        byte_step;
    logic        check_event;
    t_frame_view view;
    t_seq_cfg    seq_cfg;
    t_result     result;
    t_cfg_idx    cfg_idx;

    // The processing stage may move on whenever the output register is empty
    // or is being emptied in this cycle.
    assign out_free    = !r_out_valid || !i_out_stall;
    assign s1_go       = r_s1_valid && out_free;
    assign o_in_stall  = r_s1_valid && !out_free;
    assign in_take     = i_in_valid && !o_in_stall;
    assign n_s1_valid  = in_take || (r_s1_valid && !s1_go);

    // A byte request feeds the byte path; a check happens at frame end or on
    // a missing-frame request.
    assign byte_step   = s1_go && r_s1_nd;
    assign check_event = s1_go && (!r_s1_nd || r_s1_last);
    assign n_out_valid = check_event || (r_out_valid && i_out_stall);

    assign o_cfg_ready = 1'b1;
    assign cfg_idx     = t_cfg_idx'(i_cfg_index);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter_offset_bits <= 9'd8;
            r_crc_offset_bits     <= 9'd0;
            r_data_length_bits    <= 10'd64;
            r_max_delta_init      <= 4'd1;
            r_max_no_new          <= 4'd1;
            r_sync_init           <= 4'd0;
            r_new_mapping         <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (cfg_idx)
                CFG_COUNTER_OFFSET: r_counter_offset_bits <= i_cfg_data[8:0];
                CFG_CRC_OFFSET:     r_crc_offset_bits     <= i_cfg_data[8:0];
                CFG_DATA_LENGTH:    r_data_length_bits    <= i_cfg_data[9:0];
                CFG_MAX_DELTA:      r_max_delta_init      <= i_cfg_data[3:0];
                CFG_MAX_NO_NEW:     r_max_no_new          <= i_cfg_data[3:0];
                CFG_SYNC_INIT:      r_sync_init           <= i_cfg_data[3:0];
                CFG_NEW_MAPPING:    r_new_mapping         <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Input register: control cleared by reset, payload loaded on accept.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_byte <= i_frame_byte;
            r_s1_last <= i_last_byte;
            r_s1_nd   <= i_new_data;
        end
    end

    efc_frame_acc u_frame_acc (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_byte_step           (byte_step),
        .i_frame_end           (r_s1_last),
        .i_frame_byte          (r_s1_byte),
        .i_counter_offset_bits (r_counter_offset_bits),
        .i_crc_offset_bits     (r_crc_offset_bits),
        .i_data_length_bits    (r_data_length_bits),
        .o_view                (view)
    );

    assign seq_cfg.max_delta_init = r_max_delta_init;
    assign seq_cfg.max_no_new     = r_max_no_new;
    assign seq_cfg.sync_init      = r_sync_init;
    assign seq_cfg.new_mapping    = r_new_mapping;

    efc_seq_check u_seq_check (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_event    (check_event),
        .i_new_data (r_s1_nd),
        .i_view     (view),
        .i_cfg      (seq_cfg),
        .o_result   (result)
    );

    // Output register: holds the result while the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (check_event) begin
            r_out <= result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_check_status   = r_out.check_status;
    assign o_return_code    = r_out.return_code;
    assign o_lost_frames    = r_out.lost_frames;
    assign o_generic_status = r_out.generic_status;

endmodule
